// ===== hw/rtl/pnc_pkg.sv =====
// ----------------------------------------------------------------------------
// pnc_pkg
// shared constants, field widths and control types of the neighbor census core
// ----------------------------------------------------------------------------
package pnc_pkg;

	localparam int GRID_SIDE_DEF = 64;

	localparam int COORD_W  = 6;
	localparam int IN_W     = 16;
	localparam int WIDE_W   = 15;
	localparam int NARROW_W = 13;
	localparam int COUNT_W  = 13;
	localparam int OUT_W    = 88;

	typedef enum logic [5:0] {
		ST_INIT   = 6'b000001,
		ST_LOAD   = 6'b000010,
		ST_SETTLE = 6'b000100,
		ST_SCAN   = 6'b001000,
		ST_DRAIN  = 6'b010000,
		ST_EMIT   = 6'b100000
	} state_t;

	typedef struct packed {
		logic clear_run;
		logic load_accept;
		logic scan_init;
		logic scan_run;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic scan_done;
	} sts_t;

endpackage

// ===== hw/rtl/polyomino_neighbor_census_core.sv =====
// ----------------------------------------------------------------------------
// polyomino_neighbor_census_core
// site-perimeter census of one polyomino loaded cell by cell into a grid
//
// channel   dir  transaction  payload
// s_axis    in   one cell     tdata: cell_x, cell_y ; tlast: last_cell
// m_axis    out  one census   tdata: site_perimeter, side_total, shared_sides,
//                             empty_two, empty_three, empty_four
//
// cells load at one per cycle while s_axis_tready is high, via both grid ram ports
// after the last cell the core settles, scans the grid, then drains and emits;
// the scan walks the ram one cell per cycle and clears it behind itself
// after reset the grid is cleared while s_axis_tready is low
// a result waiting on m_axis stalls only the finish of the next scan
// ----------------------------------------------------------------------------
module polyomino_neighbor_census_core import pnc_pkg::*; #(
	parameter int GRID_SIDE = GRID_SIDE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // cell_x, cell_y
	input  logic             s_axis_tlast,  // last_cell
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata   // site_perimeter, side_total, shared_sides,
	                                        // empty_two, empty_three, empty_four
);

	cmd_t cmd;
	sts_t sts;

	pnc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_last   (s_axis_tlast),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pnc_dpath #(
		.GRID_SIDE (GRID_SIDE)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.cell_x (s_axis_tdata[COORD_W-1:0]),
		.cell_y (s_axis_tdata[2*COORD_W-1:COORD_W]),
		.result (m_axis_tdata)
	);

	// no cell taken while the grid is swept
	a_no_load_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && (cmd.scan_run || cmd.clear_run)))
		else $error("cell accepted during grid sweep");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result overwritten");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> m_axis_tvalid)
		else $error("census not presented");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_run && sts.scan_done) |=> (!cmd.scan_run && !s_axis_tready))
		else $error("scan did not stop at its end");

endmodule

// ===== hw/rtl/pnc_ram.sv =====
// ----------------------------------------------------------------------------
// pnc_ram
// simple dual-port ram, one write and one registered read port, read-first
// ----------------------------------------------------------------------------
module pnc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/pnc_dpath.sv =====
// ----------------------------------------------------------------------------
// pnc_dpath
// occupancy grid, load path with duplicate check, raster scan with line
// window, census accumulators and result register
// ----------------------------------------------------------------------------
module pnc_dpath import pnc_pkg::*; #(
	parameter int GRID_SIDE = GRID_SIDE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [COORD_W-1:0] cell_x,
	input  logic [COORD_W-1:0] cell_y,
	output logic [OUT_W-1:0]   result
);

	localparam int CELLS = GRID_SIDE * GRID_SIDE;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(CELLS + GRID_SIDE);
	localparam int CLW   = $clog2(GRID_SIDE);
	localparam int LW    = 2 * GRID_SIDE;

	logic [CW-1:0]      pos_q;
	logic [CLW-1:0]     col_q;
	logic               is_read;
	logic               is_eval;

	logic [AW-1:0]      in_addr;
	logic               in_ok;
	logic               ld_vld_s1;
	logic               ld_ok_s1;
	logic [AW-1:0]      ld_addr_s1;
	logic               wr_vld_q;
	logic [AW-1:0]      wr_addr_q;
	logic               occ;
	logic               ld_we;
	logic [COUNT_W-1:0] cell_cnt_q;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [AW-1:0]      ram_raddr;
	logic               rd_data;

	logic               act_s1;
	logic               rdv_s1;
	logic               ev_s1;
	logic [CLW-1:0]     col_s1;
	logic [LW-1:0]      line_q;

	logic               up;
	logic               dn;
	logic               lft;
	logic               rgt;
	logic               ctr;
	logic [2:0]         k;
	logic [WIDE_W-1:0]  loss_inc;

	logic [WIDE_W-1:0]  shared_q;
	logic [WIDE_W-1:0]  two_q;
	logic [WIDE_W-1:0]  three_q;
	logic [WIDE_W-1:0]  four_q;
	logic [WIDE_W-1:0]  loss_q;
	logic [WIDE_W-1:0]  total;
	logic [WIDE_W-1:0]  perim;
	logic [OUT_W-1:0]   result_q;

	// scan / clear position
	assign is_read = pos_q < CW'(CELLS);
	assign is_eval = pos_q >= CW'(GRID_SIDE);
	assign sts.clear_done = pos_q == CW'(CELLS - 1);
	assign sts.scan_done  = pos_q == CW'(CELLS + GRID_SIDE - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			col_q <= '0;
		end else if (cmd.scan_init) begin
			pos_q <= '0;
			col_q <= '0;
		end else if (cmd.clear_run) begin
			pos_q <= sts.clear_done ? '0 : pos_q + CW'(1);
		end else if (cmd.scan_run) begin
			pos_q <= sts.scan_done ? '0 : pos_q + CW'(1);
			col_q <= (col_q == CLW'(GRID_SIDE - 1)) ? '0 : col_q + CLW'(1);
		end
	end

	// load path
	assign in_addr = AW'(int'(cell_y) * GRID_SIDE + int'(cell_x));
	assign in_ok   = (int'(cell_x) < GRID_SIDE) && (int'(cell_y) < GRID_SIDE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_vld_s1 <= 1'b0;
			wr_vld_q  <= 1'b0;
		end else begin
			ld_vld_s1 <= cmd.load_accept;
			wr_vld_q  <= ld_we;
		end
	end

	always_ff @(posedge clk) begin
		ld_ok_s1   <= in_ok;
		ld_addr_s1 <= in_addr;
		wr_addr_q  <= ld_addr_s1;
	end

	// previous write is not yet visible in the registered read
	assign occ   = rd_data | (wr_vld_q && (wr_addr_q == ld_addr_s1));
	assign ld_we = ld_vld_s1 && ld_ok_s1 && !occ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_cnt_q <= '0;
		end else if (cmd.emit) begin
			cell_cnt_q <= '0;
		end else if (ld_we) begin
			cell_cnt_q <= cell_cnt_q + COUNT_W'(1);
		end
	end

	// grid memory, scan clears each cell as it reads it
	assign ram_we    = ld_we | cmd.clear_run | (cmd.scan_run & is_read);
	assign ram_waddr = ld_we ? ld_addr_s1 : pos_q[AW-1:0];
	assign ram_raddr = cmd.scan_run ? pos_q[AW-1:0] : in_addr;

	pnc_ram #(
		.WIDTH (1),
		.DEPTH (CELLS)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ld_we),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	// scan window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
			rdv_s1 <= 1'b0;
			ev_s1  <= 1'b0;
			col_s1 <= '0;
		end else begin
			act_s1 <= cmd.scan_run;
			rdv_s1 <= is_read;
			ev_s1  <= is_eval;
			col_s1 <= col_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			line_q <= '0;
		end else if (act_s1) begin
			line_q <= {line_q[LW-2:0], dn};
		end
	end

	assign dn  = rdv_s1 & rd_data;
	assign up  = line_q[LW-1];
	assign ctr = line_q[GRID_SIDE-1];
	assign lft = line_q[GRID_SIDE] & (col_s1 != '0);
	assign rgt = line_q[GRID_SIDE-2] & (col_s1 != CLW'(GRID_SIDE - 1));
	assign k   = {2'b00, up} + {2'b00, dn} + {2'b00, lft} + {2'b00, rgt};

	always_comb begin
		if (ctr) begin
			loss_inc = WIDE_W'(k);
		end else if (k >= 3'd2) begin
			loss_inc = WIDE_W'(k - 3'd1);
		end else begin
			loss_inc = '0;
		end
	end

	// census accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shared_q <= '0;
			two_q    <= '0;
			three_q  <= '0;
			four_q   <= '0;
			loss_q   <= '0;
		end else if (cmd.scan_init) begin
			shared_q <= '0;
			two_q    <= '0;
			three_q  <= '0;
			four_q   <= '0;
			loss_q   <= '0;
		end else if (act_s1 && ev_s1) begin
			loss_q <= loss_q + loss_inc;
			if (ctr) begin
				shared_q <= shared_q + WIDE_W'(k);
			end else begin
				case (k)
					3'd2:    two_q   <= two_q + WIDE_W'(1);
					3'd3:    three_q <= three_q + WIDE_W'(1);
					3'd4:    four_q  <= four_q + WIDE_W'(1);
					default: ;
				endcase
			end
		end
	end

	// result register
	assign total = {cell_cnt_q, 2'b00};
	assign perim = total - loss_q;

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q <= {4'b0000, four_q[NARROW_W-1:0], three_q[NARROW_W-1:0],
				two_q[NARROW_W-1:0], shared_q, total, perim};
		end
	end

	assign result = result_q;

endmodule

// ===== hw/rtl/pnc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pnc_ctrl
// sequencer for grid clear, cell load, scan and result hand-off
// ----------------------------------------------------------------------------
module pnc_ctrl import pnc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.clear_run = 1'b1;
				if (sts.clear_done) begin
					state_nxt = ST_LOAD;
				end
			end
			ST_LOAD: begin
				in_ready        = 1'b1;
				cmd.load_accept = in_valid;
				if (in_valid && in_last) begin
					state_nxt = ST_SETTLE;
				end
			end
			ST_SETTLE: begin
				cmd.scan_init = 1'b1;
				state_nxt     = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_LOAD;
				end
			end
			default: begin
				state_nxt = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
